// File: src/sgaa_pkg.sv
// shared types and constants for the semi-global affine alignment core
package sgaa_pkg;

    localparam int RES_W   = 5;
    localparam int IDX_W   = 5;
    localparam int ENTRY_W = 8;
    localparam int MODE_W  = 2;
    localparam int PEN_W   = 8;
    localparam int SCORE_W = 32;
    localparam int OUT_SCORE_W   = 23;
    localparam int OUT_MATCHES_W = 11;
    localparam int OUT_LENGTH_W  = 12;
    localparam int STATUS_W      = 2;

    localparam logic signed [SCORE_W-1:0] NEG_INF = -32'sd1073741824;
    localparam logic signed [SCORE_W-1:0] OUT_SCORE_MAX = 32'sd4194303;
    localparam logic signed [SCORE_W-1:0] OUT_SCORE_MIN = -32'sd4194304;

    localparam logic [MODE_W-1:0] MODE_TABLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    localparam logic CFG_GAP_OPEN   = 1'b0;
    localparam logic CFG_GAP_EXTEND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_CELL_RD,
        ST_CELL_LD,
        ST_CELL_EX,
        ST_DONE
    } state_t;

endpackage

// File: src/sgaa_ram.sv
// generic single write port ram with registered read
module sgaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/sgaa_cell.sv
// one dynamic programming cell: gap updates, diagonal score and tie-ordered pick
module sgaa_cell #(
    parameter int MW = 11,
    parameter int LW = 12
) (
    input  logic signed [sgaa_pkg::SCORE_W-1:0] diag_s,
    input  logic [MW-1:0]                       diag_m,
    input  logic [LW-1:0]                       diag_l,
    input  logic signed [sgaa_pkg::SCORE_W-1:0] up_s,
    input  logic [MW-1:0]                       up_m,
    input  logic [LW-1:0]                       up_l,
    input  logic signed [sgaa_pkg::SCORE_W-1:0] del_prev,
    input  logic signed [sgaa_pkg::SCORE_W-1:0] left_s,
    input  logic [LW-1:0]                       left_l,
    input  logic signed [sgaa_pkg::SCORE_W-1:0] ins_prev,
    input  logic [sgaa_pkg::PEN_W-1:0]          gap_open,
    input  logic [sgaa_pkg::PEN_W-1:0]          gap_extend,
    input  logic signed [sgaa_pkg::ENTRY_W-1:0] subst,
    input  logic                                is_match,
    input  logic [MW-1:0]                       left_m,
    output logic signed [sgaa_pkg::SCORE_W-1:0] del_out,
    output logic signed [sgaa_pkg::SCORE_W-1:0] ins_out,
    output logic signed [sgaa_pkg::SCORE_W-1:0] s_out,
    output logic [MW-1:0]                       m_out,
    output logic [LW-1:0]                       l_out
);
    logic signed [sgaa_pkg::SCORE_W-1:0] go_s, ge_s, d_open, d_ext, i_open, i_ext, sub;

    always_comb begin
        go_s   = sgaa_pkg::SCORE_W'(gap_open);
        ge_s   = sgaa_pkg::SCORE_W'(gap_extend);
        d_open = up_s - go_s;
        d_ext  = del_prev - ge_s;
        i_open = left_s - go_s;
        i_ext  = ins_prev - ge_s;
        del_out = (d_open > d_ext) ? d_open : d_ext;
        ins_out = (i_open > i_ext) ? i_open : i_ext;
        sub = diag_s + sgaa_pkg::SCORE_W'(subst);
        // diagonal wins ties, then deletion
        if (sub >= del_out && sub >= ins_out) begin
            s_out = sub;
            m_out = diag_m + MW'(is_match);
            l_out = diag_l + LW'(1);
        end else if (del_out >= ins_out) begin
            s_out = del_out;
            m_out = up_m;
            l_out = up_l + LW'(1);
        end else begin
            s_out = ins_out;
            m_out = left_m;
            l_out = left_l + LW'(1);
        end
    end
endmodule

// File: src/semiglobal_affine_align_stats_core.sv
// top level: loads, sequencer and working rows of the semi-global alignment core
// run: the one shared cell unit serves each cell through CELL_RD, CELL_LD and
// CELL_EX behind registered memory reads
// throughput: one load per cycle while idle; one run at a time, not ready
// during it
// reset: synchronous active low, clears counts, flags and state, sets gap open
// to 10 and gap extend to 1; table, sequence and row memories are not cleared
module semiglobal_affine_align_stats_core #(
    parameter int MAX_FIRST_LEN  = 1024,
    parameter int MAX_SECOND_LEN = 1024,
    parameter int ALPHABET_SIZE  = 24
) (
    input  logic aclk,
    input  logic aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [sgaa_pkg::PEN_W-1:0]    cfg_data,
    // input requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sgaa_pkg::MODE_W-1:0]   s_mode,
    input  logic [sgaa_pkg::IDX_W-1:0]    s_row_index,
    input  logic [sgaa_pkg::IDX_W-1:0]    s_col_index,
    input  logic signed [sgaa_pkg::ENTRY_W-1:0] s_entry_value,
    input  logic [sgaa_pkg::RES_W-1:0]    s_residue,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sgaa_pkg::OUT_SCORE_W-1:0] m_best_score,
    output logic [sgaa_pkg::OUT_MATCHES_W-1:0]      m_best_matches,
    output logic [sgaa_pkg::OUT_LENGTH_W-1:0]       m_best_length,
    output logic [sgaa_pkg::STATUS_W-1:0]           m_status
);
    localparam int FCW = $clog2(MAX_FIRST_LEN + 1);
    localparam int SCW = $clog2(MAX_SECOND_LEN + 1);
    localparam int FAW = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
    localparam int SAW = (MAX_SECOND_LEN > 1) ? $clog2(MAX_SECOND_LEN) : 1;
    localparam int RDEPTH = MAX_SECOND_LEN + 1;
    localparam int RAW = SCW;
    localparam int TDEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TAW = $clog2(TDEPTH);
    localparam int MW = $clog2(MAX_FIRST_LEN + 1);
    localparam int LW = $clog2(MAX_FIRST_LEN + MAX_SECOND_LEN + 1);
    localparam int SW = sgaa_pkg::SCORE_W;
    localparam int RW = sgaa_pkg::RES_W;

    // gap penalties
    logic [sgaa_pkg::PEN_W-1:0] gap_open_reg, gap_extend_reg;

    // load bookkeeping
    logic [FCW-1:0] first_count_reg;
    logic [SCW-1:0] second_count_reg;
    logic           dropped_reg;

    // sequencer
    sgaa_pkg::state_t state_reg, state_next;
    logic [FCW-1:0] i_reg;
    logic [SCW-1:0] j_reg;

    // per row and per cell working registers
    logic [RW-1:0]        a_reg, b_reg;
    logic                 a_ok_reg, b_ok_reg;
    logic signed [SW-1:0] diag_s_reg, up_s_reg, del_prev_reg, left_s_reg, ins_reg;
    logic [MW-1:0]        diag_m_reg, up_m_reg, left_m_reg;
    logic [LW-1:0]        diag_l_reg, up_l_reg, left_l_reg;

    // running best
    logic signed [SW-1:0] best_s_reg;
    logic [MW-1:0]        best_m_reg;
    logic [LW-1:0]        best_l_reg;
    logic [sgaa_pkg::STATUS_W-1:0] status_reg;

    // result register
    logic                 m_valid_reg;
    logic signed [sgaa_pkg::OUT_SCORE_W-1:0] out_s_reg;
    logic [sgaa_pkg::OUT_MATCHES_W-1:0]      out_m_reg;
    logic [sgaa_pkg::OUT_LENGTH_W-1:0]       out_l_reg;
    logic [sgaa_pkg::STATUS_W-1:0]           out_st_reg;

    logic s_fire, cfg_fire, out_free;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_ready   = (state_reg == sgaa_pkg::ST_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;

    assign m_valid        = m_valid_reg;
    assign m_best_score   = out_s_reg;
    assign m_best_matches = out_m_reg;
    assign m_best_length  = out_l_reg;
    assign m_status       = out_st_reg;

    // ---------------- substitution table ----------------
    logic          tab_we;
    logic [TAW-1:0] tab_waddr, tab_raddr;
    logic [sgaa_pkg::ENTRY_W-1:0] tab_rdata;
    logic [10:0]   tab_wprod, tab_rprod;
    logic          tab_w_ok;

    // residues fetched for the current row and column, straight from the sequence memories
    logic [RW-1:0] sec_rdata, fst_rdata;
    logic          b_in_range;

    assign tab_w_ok  = ({1'b0, s_row_index} < 6'(ALPHABET_SIZE)) &&
                       ({1'b0, s_col_index} < 6'(ALPHABET_SIZE));
    assign tab_wprod = 11'(s_row_index) * 11'(ALPHABET_SIZE) + 11'(s_col_index);
    assign tab_waddr = TAW'(tab_wprod);
    assign tab_we    = s_fire && (s_mode == sgaa_pkg::MODE_TABLE) && tab_w_ok;
    assign tab_rprod = 11'(a_reg) * 11'(ALPHABET_SIZE) + 11'(sec_rdata);
    assign tab_raddr = TAW'(tab_rprod);
    assign b_in_range = ({1'b0, sec_rdata} < 6'(ALPHABET_SIZE));

    sgaa_ram #(.WIDTH(sgaa_pkg::ENTRY_W), .DEPTH(TDEPTH)) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (s_entry_value),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // ---------------- residue sequences ----------------
    logic fst_we, sec_we;
    logic [FAW-1:0] fst_raddr;
    logic [SAW-1:0] sec_raddr;
    logic [FCW-1:0] i_minus;
    logic [SCW-1:0] j_minus;

    assign fst_we = s_fire && (s_mode == sgaa_pkg::MODE_FIRST) &&
                    (first_count_reg < FCW'(MAX_FIRST_LEN));
    assign sec_we = s_fire && (s_mode == sgaa_pkg::MODE_SECOND) &&
                    (second_count_reg < SCW'(MAX_SECOND_LEN));
    assign i_minus   = i_reg - FCW'(1);
    assign j_minus   = j_reg - SCW'(1);
    assign fst_raddr = i_minus[FAW-1:0];
    assign sec_raddr = j_minus[SAW-1:0];

    sgaa_ram #(.WIDTH(RW), .DEPTH(MAX_FIRST_LEN)) u_first (
        .aclk  (aclk),
        .we    (fst_we),
        .waddr (first_count_reg[FAW-1:0]),
        .wdata (s_residue),
        .raddr (fst_raddr),
        .rdata (fst_rdata)
    );

    sgaa_ram #(.WIDTH(RW), .DEPTH(MAX_SECOND_LEN)) u_second (
        .aclk  (aclk),
        .we    (sec_we),
        .waddr (second_count_reg[SAW-1:0]),
        .wdata (s_residue),
        .raddr (sec_raddr),
        .rdata (sec_rdata)
    );

    // ---------------- working rows ----------------
    logic           row_we, del_we;
    logic [RAW-1:0] row_waddr, row_raddr;
    logic signed [SW-1:0] rs_wdata, rd_wdata, rs_rdata, rd_rdata;
    logic [MW-1:0]  rm_wdata, rm_rdata;
    logic [LW-1:0]  rl_wdata, rl_rdata;

    sgaa_ram #(.WIDTH(SW), .DEPTH(RDEPTH)) u_row_score (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(rs_wdata),
        .raddr(row_raddr), .rdata(rs_rdata)
    );
    sgaa_ram #(.WIDTH(SW), .DEPTH(RDEPTH)) u_row_del (
        .aclk(aclk), .we(del_we), .waddr(row_waddr), .wdata(rd_wdata),
        .raddr(row_raddr), .rdata(rd_rdata)
    );
    sgaa_ram #(.WIDTH(MW), .DEPTH(RDEPTH)) u_row_matches (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(rm_wdata),
        .raddr(row_raddr), .rdata(rm_rdata)
    );
    sgaa_ram #(.WIDTH(LW), .DEPTH(RDEPTH)) u_row_length (
        .aclk(aclk), .we(row_we), .waddr(row_waddr), .wdata(rl_wdata),
        .raddr(row_raddr), .rdata(rl_rdata)
    );

    // ---------------- shared cell unit ----------------
    logic signed [SW-1:0] c_del, c_ins, c_s;
    logic [MW-1:0]        c_m;
    logic [LW-1:0]        c_l;
    logic signed [sgaa_pkg::ENTRY_W-1:0] c_subst;
    logic                 c_match;

    // out-of-range residues score zero against anything
    assign c_subst = (a_ok_reg && b_ok_reg) ? tab_rdata : '0;
    assign c_match = (a_reg == b_reg);

    sgaa_cell #(.MW(MW), .LW(LW)) u_cell (
        .diag_s     (diag_s_reg),
        .diag_m     (diag_m_reg),
        .diag_l     (diag_l_reg),
        .up_s       (up_s_reg),
        .up_m       (up_m_reg),
        .up_l       (up_l_reg),
        .del_prev   (del_prev_reg),
        .left_s     (left_s_reg),
        .left_l     (left_l_reg),
        .ins_prev   (ins_reg),
        .gap_open   (gap_open_reg),
        .gap_extend (gap_extend_reg),
        .subst      (c_subst),
        .is_match   (c_match),
        .left_m     (left_m_reg),
        .del_out    (c_del),
        .ins_out    (c_ins),
        .s_out      (c_s),
        .m_out      (c_m),
        .l_out      (c_l)
    );

    // best is checked on every cell of the last row and on the last column
    logic last_col, last_row, best_take;
    assign last_col  = (j_reg == second_count_reg);
    assign last_row  = (i_reg == first_count_reg);
    assign best_take = (last_row || last_col) && (c_s > best_s_reg);

    // memory port steering per state
    always_comb begin
        row_we    = 1'b0;
        del_we    = 1'b0;
        row_waddr = j_reg;
        row_raddr = j_reg;
        rs_wdata  = c_s;
        rd_wdata  = c_del;
        rm_wdata  = c_m;
        rl_wdata  = c_l;
        case (state_reg)
            sgaa_pkg::ST_INIT: begin
                row_we   = 1'b1;
                del_we   = 1'b1;
                rs_wdata = '0;
                rd_wdata = sgaa_pkg::NEG_INF;
                rm_wdata = '0;
                rl_wdata = '0;
            end
            sgaa_pkg::ST_ROW_RD: begin
                row_raddr = '0;
            end
            sgaa_pkg::ST_ROW_LD: begin
                // column zero restarts at zero: leading gaps are free
                row_we    = 1'b1;
                row_waddr = '0;
                rs_wdata  = '0;
                rm_wdata  = '0;
                rl_wdata  = '0;
            end
            sgaa_pkg::ST_CELL_EX: begin
                row_we = 1'b1;
                del_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sgaa_pkg::ST_IDLE: begin
                if (s_fire && s_mode == sgaa_pkg::MODE_RUN) begin
                    if (first_count_reg == '0 || second_count_reg == '0) begin
                        state_next = sgaa_pkg::ST_DONE;
                    end else begin
                        state_next = sgaa_pkg::ST_INIT;
                    end
                end
            end
            sgaa_pkg::ST_INIT: begin
                if (last_col) begin
                    state_next = sgaa_pkg::ST_ROW_RD;
                end
            end
            sgaa_pkg::ST_ROW_RD:  state_next = sgaa_pkg::ST_ROW_LD;
            sgaa_pkg::ST_ROW_LD:  state_next = sgaa_pkg::ST_CELL_RD;
            sgaa_pkg::ST_CELL_RD: state_next = sgaa_pkg::ST_CELL_LD;
            sgaa_pkg::ST_CELL_LD: state_next = sgaa_pkg::ST_CELL_EX;
            sgaa_pkg::ST_CELL_EX: begin
                if (!last_col) begin
                    state_next = sgaa_pkg::ST_CELL_RD;
                end else if (last_row) begin
                    state_next = sgaa_pkg::ST_DONE;
                end else begin
                    state_next = sgaa_pkg::ST_ROW_RD;
                end
            end
            sgaa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sgaa_pkg::ST_IDLE;
                end
            end
            default: state_next = sgaa_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sgaa_pkg::ST_IDLE;
            gap_open_reg     <= 8'd10;
            gap_extend_reg   <= 8'd1;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                case (cfg_index)
                    sgaa_pkg::CFG_GAP_OPEN:   gap_open_reg   <= cfg_data;
                    sgaa_pkg::CFG_GAP_EXTEND: gap_extend_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            // appends past capacity are dropped and flagged
            if (s_fire && s_mode == sgaa_pkg::MODE_FIRST) begin
                if (fst_we) begin
                    first_count_reg <= first_count_reg + FCW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (s_fire && s_mode == sgaa_pkg::MODE_SECOND) begin
                if (sec_we) begin
                    second_count_reg <= second_count_reg + SCW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == sgaa_pkg::ST_DONE && out_free) begin
                m_valid_reg      <= 1'b1;
                first_count_reg  <= '0;
                second_count_reg <= '0;
                dropped_reg      <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            sgaa_pkg::ST_IDLE: begin
                j_reg <= '0;
                if (first_count_reg == '0 || second_count_reg == '0) begin
                    best_s_reg <= '0;
                    status_reg <= sgaa_pkg::STATUS_EMPTY;
                end else begin
                    best_s_reg <= sgaa_pkg::NEG_INF;
                    status_reg <= dropped_reg ? sgaa_pkg::STATUS_DROPPED
                                              : sgaa_pkg::STATUS_OK;
                end
                best_m_reg <= '0;
                best_l_reg <= '0;
            end
            sgaa_pkg::ST_INIT: begin
                j_reg <= j_reg + SCW'(1);
                i_reg <= FCW'(1);
            end
            sgaa_pkg::ST_ROW_LD: begin
                a_reg      <= fst_rdata;
                a_ok_reg   <= ({1'b0, fst_rdata} < 6'(ALPHABET_SIZE));
                up_s_reg   <= rs_rdata;
                up_m_reg   <= rm_rdata;
                up_l_reg   <= rl_rdata;
                left_s_reg <= '0;
                left_m_reg <= '0;
                left_l_reg <= '0;
                ins_reg    <= sgaa_pkg::NEG_INF;
                j_reg      <= SCW'(1);
            end
            sgaa_pkg::ST_CELL_LD: begin
                // old up moves to diagonal, fresh row value becomes up
                diag_s_reg   <= up_s_reg;
                diag_m_reg   <= up_m_reg;
                diag_l_reg   <= up_l_reg;
                up_s_reg     <= rs_rdata;
                up_m_reg     <= rm_rdata;
                up_l_reg     <= rl_rdata;
                del_prev_reg <= rd_rdata;
                b_reg        <= sec_rdata;
                b_ok_reg     <= b_in_range;
            end
            sgaa_pkg::ST_CELL_EX: begin
                left_s_reg <= c_s;
                left_m_reg <= c_m;
                left_l_reg <= c_l;
                ins_reg    <= c_ins;
                if (best_take) begin
                    best_s_reg <= c_s;
                    best_m_reg <= c_m;
                    best_l_reg <= c_l;
                end
                if (last_col) begin
                    i_reg <= i_reg + FCW'(1);
                end else begin
                    j_reg <= j_reg + SCW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result register with saturation to the output field ranges
    always_ff @(posedge aclk) begin
        if (state_reg == sgaa_pkg::ST_DONE && out_free) begin
            if (best_s_reg > sgaa_pkg::OUT_SCORE_MAX) begin
                out_s_reg <= sgaa_pkg::OUT_SCORE_W'(sgaa_pkg::OUT_SCORE_MAX);
            end else if (best_s_reg < sgaa_pkg::OUT_SCORE_MIN) begin
                out_s_reg <= sgaa_pkg::OUT_SCORE_W'(sgaa_pkg::OUT_SCORE_MIN);
            end else begin
                out_s_reg <= best_s_reg[sgaa_pkg::OUT_SCORE_W-1:0];
            end
            if (32'(best_m_reg) > 32'd2047) begin
                out_m_reg <= '1;
            end else begin
                out_m_reg <= sgaa_pkg::OUT_MATCHES_W'(best_m_reg);
            end
            if (32'(best_l_reg) > 32'd4095) begin
                out_l_reg <= '1;
            end else begin
                out_l_reg <= sgaa_pkg::OUT_LENGTH_W'(best_l_reg);
            end
            out_st_reg <= status_reg;
        end
    end
endmodule
